// File: rtl/pfns_pkg.sv
// ============================================================================
// Prefix filter next-character set: shared package
// Request and response types, item kinds, error codes and status values.
// ============================================================================
package pfns_pkg;

    // Prefix store depth; the usable prefix length is the smaller of this
    // and the line length limit.
    localparam int PREFIX_DEPTH = 128;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] NUL_BYTE     = 8'h00;

    // Request kinds.
    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_PREFIX = 3'd1;
    localparam logic [2:0] KIND_LINE   = 3'd2;
    localparam logic [2:0] KIND_EOL    = 3'd3;
    localparam logic [2:0] KIND_REPORT = 3'd4;
    localparam logic [2:0] KIND_READ   = 3'd5;

    // Sticky error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LINE   = 2'd1;
    localparam logic [1:0] ERR_PREFIX = 2'd2;

    typedef enum logic [2:0] {
        ST_NOT_FOUND   = 3'd0,
        ST_FOUND       = 3'd1,
        ST_ENABLE      = 3'd2,
        ST_LINE_LONG   = 3'd3,
        ST_PREFIX_LONG = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_value;
        logic [6:0] read_index;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] match_count;
        logic [1:0]  mask_index;
        logic [63:0] mask_word;
        logic [7:0]  found_length;
        logic [7:0]  found_char;
        logic        last;
    } t_out_rsp;

    // Next-character set as four 64-bit quarters.
    typedef logic [3:0][63:0] t_set;

    // Query state as seen by a report or read at the moment it is accepted.
    typedef struct packed {
        t_status     status;
        logic [15:0] match_count;
        logic [7:0]  found_length;
        logic        rd_hit;
    } t_snap;

    // Line store write port.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] pos;
        logic [7:0] data;
    } t_lwr;

    // Line store read port.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [6:0] index;
    } t_lrd;

endpackage

// File: rtl/prefix_filter_next_char_set_core.sv
// ============================================================================
// Prefix filter next-character set: top level
// Byte-stream prefix filter producing match status and next-character set.
// ============================================================================
// The block takes one request per cycle; only a report or read can stall,
// while the response sequencer is busy. Prefix bytes, line bytes, end of
// line and clear are absorbed at full rate, as each at most writes the
// prefix or line memory and touches a few counters; the prefix compare for
// a line byte reads the prefix memory and resolves in the following cycle.
// A read of the stored matching line returns one result; reads may follow
// each other every cycle while the output is not stalled. A report
// returns four results, one 64-bit quarter of the set per cycle while the
// output is not stalled, and holds the sequencer until its last quarter is
// issued. Results sit in an output register, so new requests are taken
// while a result still waits for the consumer. No memory needs clearing
// after reset. A line over LINE_CHARS bytes or a prefix over the usable
// prefix length sets a sticky error that only a clear or reset removes.
module prefix_filter_next_char_set_core #(
    parameter int LINE_CHARS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pfns_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pfns_pkg::t_out_rsp o_out
);

    logic            w_acc;
    logic            w_free;
    logic            w_makes_result;
    pfns_pkg::t_snap w_snap;
    pfns_pkg::t_set  w_set;
    pfns_pkg::t_lwr  w_lwr;
    pfns_pkg::t_lrd  w_lrd;
    logic [7:0]      w_rd_data;

    // Only reports and reads need the response sequencer; everything else
    // is accepted regardless of the output side.
    assign w_makes_result = (i_in.kind == pfns_pkg::KIND_REPORT)
                            || (i_in.kind == pfns_pkg::KIND_READ);
    assign o_in_stall     = w_makes_result && !w_free;
    assign w_acc          = i_in_valid && !o_in_stall;

    pfns_core #(
        .LINE_CHARS (LINE_CHARS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_req   (i_in),
        .o_snap  (w_snap),
        .o_set   (w_set),
        .o_lwr   (w_lwr),
        .o_lrd   (w_lrd)
    );

    pfns_line_store #(
        .LINE_CHARS (LINE_CHARS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_lwr     (w_lwr),
        .i_lrd     (w_lrd),
        .o_rd_data (w_rd_data)
    );

    pfns_resp u_resp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_kind      (i_in.kind),
        .i_snap      (w_snap),
        .i_set       (w_set),
        .i_rd_data   (w_rd_data),
        .i_out_stall (i_out_stall),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// File: rtl/pfns_line_store.sv
// ============================================================================
// Prefix filter next-character set: line store
// Two-bank byte memory holding the line being received and the last match.
// ============================================================================
module pfns_line_store #(
    parameter int LINE_CHARS = 128
) (
    input  logic            i_clk,
    input  pfns_pkg::t_lwr  i_lwr,
    input  pfns_pkg::t_lrd  i_lrd,
    output logic [7:0]      o_rd_data
);

    localparam int PW    = (LINE_CHARS > 2) ? $clog2(LINE_CHARS) : 1;
    localparam int DEPTH = 2 * (1 << PW);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] w_ri8;

    assign w_ri8 = {1'b0, i_lrd.index};

    // The write goes to the working bank and the read to the found bank,
    // so the two never touch the same entry.
    always_ff @(posedge i_clk) begin
        if (i_lwr.en) begin
            r_mem[{i_lwr.bank, i_lwr.pos[PW-1:0]}] <= i_lwr.data;
        end
        if (i_lrd.en) begin
            r_rd_data <= r_mem[{i_lrd.bank, w_ri8[PW-1:0]}];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pfns_core.sv
// ============================================================================
// Prefix filter next-character set: query state
// Prefix store, per-line compare, next-character set, count and error.
// ============================================================================
module pfns_core #(
    parameter int LINE_CHARS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  pfns_pkg::t_in_req i_req,
    output pfns_pkg::t_snap   o_snap,
    output pfns_pkg::t_set    o_set,
    output pfns_pkg::t_lwr    o_lwr,
    output pfns_pkg::t_lrd    o_lrd
);

    localparam int PLIM = (LINE_CHARS < pfns_pkg::PREFIX_DEPTH) ? LINE_CHARS
                                                                : pfns_pkg::PREFIX_DEPTH;
    localparam logic [7:0] PLIM8 = 8'(PLIM);
    localparam logic [7:0] LC8   = 8'(LINE_CHARS);

    logic [7:0]   r_pre_mem [pfns_pkg::PREFIX_DEPTH];
    logic [7:0]   r_pre_rd;
    logic [7:0]   r_cmp_char, n_cmp_char;
    logic         r_cmp_valid, n_cmp_valid;
    logic [7:0]   r_plen, n_plen;
    logic         r_bank, n_bank;
    logic [7:0]   r_slen, n_slen;
    logic [7:0]   r_lpos, n_lpos;
    logic         r_mis, n_mis;
    logic [7:0]   r_follow, n_follow;
    logic [255:0] r_set, n_set;
    logic [15:0]  r_count, n_count;
    logic [1:0]   r_err, n_err;

    logic [7:0] w_c;
    logic       w_mis;
    logic       w_ok;
    logic       w_clear;
    logic       w_do_prefix, w_pre_ovf, w_pre_wr;
    logic       w_line, w_end_byte, w_eol, w_lchar, w_line_ovf, w_lwr;
    logic       w_cmp, w_follow, w_hit;
    logic [7:0] w_bit;
    pfns_pkg::t_status w_status;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    assign w_c = upcase(i_req.char_value);

    // The compare for the previous line byte resolves in the following cycle,
    // out of the prefix memory; it is folded in here so an end of line right
    // behind it still sees the full result.
    assign w_mis = r_mis | (r_cmp_valid & (r_pre_rd != r_cmp_char));

    assign w_ok        = i_acc && (r_err == pfns_pkg::ERR_NONE);
    assign w_clear     = i_acc && (i_req.kind == pfns_pkg::KIND_CLEAR);
    assign w_do_prefix = w_ok && (i_req.kind == pfns_pkg::KIND_PREFIX)
                         && (w_c != pfns_pkg::NUL_BYTE);
    assign w_pre_ovf   = w_do_prefix && (r_plen >= PLIM8);
    assign w_pre_wr    = w_do_prefix && !w_pre_ovf;
    assign w_line      = w_ok && (i_req.kind == pfns_pkg::KIND_LINE);
    assign w_end_byte  = (w_c == pfns_pkg::NUL_BYTE) || (w_c == pfns_pkg::NEWLINE_BYTE);
    assign w_eol       = (w_line && w_end_byte)
                         || (w_ok && (i_req.kind == pfns_pkg::KIND_EOL));
    assign w_lchar     = w_line && !w_end_byte;
    assign w_line_ovf  = w_lchar && (r_lpos >= LC8);
    assign w_lwr       = w_lchar && !w_line_ovf;
    assign w_cmp       = w_lwr && (r_lpos < r_plen);
    assign w_follow    = w_lwr && (r_lpos == r_plen);
    assign w_hit       = w_eol && !w_mis && (r_lpos >= r_plen);
    assign w_bit       = (r_lpos == r_plen) ? 8'd0 : r_follow;

    always_comb begin
        n_plen      = r_plen;
        n_bank      = r_bank;
        n_slen      = r_slen;
        n_lpos      = r_lpos;
        n_mis       = w_mis;
        n_follow    = r_follow;
        n_set       = r_set;
        n_count     = r_count;
        n_err       = r_err;
        n_cmp_valid = 1'b0;
        n_cmp_char  = r_cmp_char;
        if (w_clear) begin
            n_plen   = '0;
            n_bank   = 1'b0;
            n_slen   = '0;
            n_lpos   = '0;
            n_mis    = 1'b0;
            n_follow = '0;
            n_set    = '0;
            n_count  = '0;
            n_err    = pfns_pkg::ERR_NONE;
        end else begin
            if (w_pre_wr) begin
                n_plen = r_plen + 8'd1;
            end
            if (w_pre_ovf) begin
                n_err = pfns_pkg::ERR_PREFIX;
            end
            if (w_line_ovf) begin
                n_err = pfns_pkg::ERR_LINE;
            end
            if (w_lwr) begin
                n_lpos = r_lpos + 8'd1;
                if (w_cmp) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_char  = w_c;
                end
                if (w_follow) begin
                    n_follow = w_c;
                end
            end
            if (w_eol) begin
                if (w_hit) begin
                    n_set[w_bit] = 1'b1;
                    if (r_count != 16'hFFFF) begin
                        n_count = r_count + 16'd1;
                    end
                    n_bank = ~r_bank;
                    n_slen = r_lpos;
                end
                n_lpos   = '0;
                n_mis    = 1'b0;
                n_follow = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_bank      <= 1'b0;
            r_slen      <= '0;
            r_lpos      <= '0;
            r_mis       <= 1'b0;
            r_follow    <= '0;
            r_set       <= '0;
            r_count     <= '0;
            r_err       <= pfns_pkg::ERR_NONE;
            r_cmp_valid <= 1'b0;
        end else begin
            r_plen      <= n_plen;
            r_bank      <= n_bank;
            r_slen      <= n_slen;
            r_lpos      <= n_lpos;
            r_mis       <= n_mis;
            r_follow    <= n_follow;
            r_set       <= n_set;
            r_count     <= n_count;
            r_err       <= n_err;
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_char <= n_cmp_char;
    end

    // Prefix memory. A prefix byte is written at its accept edge, so a line
    // byte accepted after it already reads it.
    always_ff @(posedge i_clk) begin
        if (w_pre_wr) begin
            r_pre_mem[r_plen[6:0]] <= w_c;
        end
        if (w_cmp) begin
            r_pre_rd <= r_pre_mem[r_lpos[6:0]];
        end
    end

    always_comb begin
        priority if (r_err == pfns_pkg::ERR_LINE) begin
            w_status = pfns_pkg::ST_LINE_LONG;
        end else if (r_err == pfns_pkg::ERR_PREFIX) begin
            w_status = pfns_pkg::ST_PREFIX_LONG;
        end else if (r_count == 16'd0) begin
            w_status = pfns_pkg::ST_NOT_FOUND;
        end else if (r_count == 16'd1) begin
            w_status = pfns_pkg::ST_FOUND;
        end else begin
            w_status = pfns_pkg::ST_ENABLE;
        end
    end

    assign o_snap.status       = w_status;
    assign o_snap.match_count  = r_count;
    assign o_snap.found_length = r_slen;
    assign o_snap.rd_hit       = ({1'b0, i_req.read_index} < r_slen)
                                 && ({1'b0, i_req.read_index} < LC8);

    assign o_set = pfns_pkg::t_set'(r_set);

    assign o_lwr.en   = w_lwr;
    assign o_lwr.bank = ~r_bank;
    assign o_lwr.pos  = r_lpos;
    assign o_lwr.data = w_c;

    assign o_lrd.en    = i_acc && (i_req.kind == pfns_pkg::KIND_READ);
    assign o_lrd.bank  = r_bank;
    assign o_lrd.index = i_req.read_index;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != pfns_pkg::ERR_NONE) && !w_clear |=> r_err == $past(r_err))
        else $error("sticky error changed without a clear");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lpos <= LC8) && (r_plen <= PLIM8))
        else $error("line position or prefix length out of range");

    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit && !w_clear |=> (r_count != 16'd0) && (r_set != '0))
        else $error("matching line left no count or set bit");

endmodule

// File: rtl/pfns_resp.sv
// ============================================================================
// Prefix filter next-character set: response sequencer
// Holds one report or read and issues its results into the output register.
// ============================================================================
module pfns_resp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  logic [2:0]         i_kind,
    input  pfns_pkg::t_snap    i_snap,
    input  pfns_pkg::t_set     i_set,
    input  logic [7:0]         i_rd_data,
    input  logic               i_out_stall,
    output logic               o_free,
    output logic               o_out_valid,
    output pfns_pkg::t_out_rsp o_out
);

    logic               r_s1_valid, n_s1_valid;
    logic               r_s1_report;
    logic [1:0]         r_beat, n_beat;
    pfns_pkg::t_snap    r_s1_snap;
    pfns_pkg::t_set     r_s1_set;
    logic               r_out_valid, n_out_valid;
    pfns_pkg::t_out_rsp r_out;
    pfns_pkg::t_out_rsp w_out;

    logic w_load, w_adv, w_done;

    assign w_load = i_acc && ((i_kind == pfns_pkg::KIND_REPORT)
                              || (i_kind == pfns_pkg::KIND_READ));
    assign w_adv  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign w_done = w_adv && (!r_s1_report || (r_beat == 2'd3));
    assign o_free = !r_s1_valid || w_done;

    always_comb begin
        w_out.status       = r_s1_snap.status;
        w_out.match_count  = r_s1_snap.match_count;
        w_out.found_length = r_s1_snap.found_length;
        if (r_s1_report) begin
            w_out.mask_index = r_beat;
            w_out.mask_word  = r_s1_set[r_beat];
            w_out.found_char = '0;
            w_out.last       = (r_beat == 2'd3);
        end else begin
            w_out.mask_index = '0;
            w_out.mask_word  = '0;
            w_out.found_char = r_s1_snap.rd_hit ? i_rd_data : 8'd0;
            w_out.last       = 1'b1;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_beat     = r_beat;
        if (w_load) begin
            n_s1_valid = 1'b1;
            n_beat     = '0;
        end else if (w_done) begin
            n_s1_valid = 1'b0;
        end else if (w_adv) begin
            n_beat = r_beat + 2'd1;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_beat      <= n_beat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_report <= (i_kind == pfns_pkg::KIND_REPORT);
            r_s1_snap   <= i_snap;
            r_s1_set    <= i_set;
        end
        if (w_adv) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> o_free)
        else $error("request taken while a response was still pending");

    a_read_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_report |-> r_beat == 2'd0)
        else $error("read response advanced past its single result");

    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_s1_report && (r_beat == 2'd3) |=> o_out_valid && o_out.last)
        else $error("final report word not marked last");

endmodule
